// ----- rtl/core/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar helpers for the date add unit.
// ----------------------------------------------------------------------------
package gda_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 24;
   localparam int STATUS_W = 2;
   // Serial day numbers up to year 65535 fit in 25 bits; one more bit holds the sign.
   localparam int SERIAL_W = 26;

   localparam logic [STATUS_W-1:0] STATUS_EXACT = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH  = 2'd2;

   localparam int DAYS_PER_400Y = 146097;
   localparam int DAYS_PER_100Y = 36524;
   localparam int DAYS_PER_4Y   = 1461;
   localparam int DAYS_COMMON   = 365;
   localparam int DAYS_LEAP     = 366;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [OFFSET_W-1:0] offset_days;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Leap test by pattern: q100/q4/q1 style is used downstream; this one
   // takes the year split into its century count and remainder.
   function automatic logic leap_split(input logic [9:0] cent, input logic [6:0] rem);
      logic res;
      if (rem[1:0] != 2'd0) res = 1'b0;
      else if (rem != 7'd0) res = 1'b1;
      else res = (cent[1:0] == 2'd0);
      return res;
   endfunction

   // Days before the first of month m in a common year.
   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;
         4'd4: r = 9'd90;   4'd5: r = 9'd120;  4'd6: r = 9'd151;
         4'd7: r = 9'd181;  4'd8: r = 9'd212;  4'd9: r = 9'd243;
         4'd10: r = 9'd273; 4'd11: r = 9'd304; default: r = 9'd334;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic lp);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2: r = lp ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/gda_stream_if.sv -----
// ----------------------------------------------------------------------------
// gda_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface gda_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/gregorian_date_add_days_unit.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a signed day offset to a proleptic Gregorian date.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock unless a result at the output is
// not taken: two stages form and limit the serial day number and
// three turn it back into a date. The whole pipeline advances together, so
// a stalled result holds every stage; an empty slot at the output lets the
// pipeline advance while the consumer waits. Results below 0001-01-01 are
// clamped (status 1), results past December 31 of MAX_YEAR saturate
// (status 2).
module gregorian_date_add_days_unit #(
   parameter int MAX_YEAR = 9999
) (
   input logic   clock,
   input logic   reset,
   gda_stream_if.sink   req,
   gda_stream_if.source rsp
);
   import gda_pkg::*;

   logic                en;
   logic                s_valid;
   logic [SERIAL_W-2:0] s_serial;
   logic [STATUS_W-1:0] s_status;
   logic                d_valid;
   rsp_type             d_rsp;

   // Advance unless the output holds an item that is not taken.
   assign en = !d_valid || rsp.ready;
   assign req.ready = en;

   gda_to_serial #(.MAX_YEAR(MAX_YEAR)) u_to_serial (
      .clock, .reset, .en,
      .in_valid(req.valid), .in_req(req.payload),
      .out_valid(s_valid), .out_serial(s_serial), .out_status(s_status)
   );

   gda_to_date u_to_date (
      .clock, .reset, .en,
      .in_valid(s_valid), .in_serial(s_serial), .in_status(s_status),
      .out_valid(d_valid), .out_rsp(d_rsp)
   );

   assign rsp.valid   = d_valid;
   assign rsp.payload = d_rsp;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed while stalled");
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status == STATUS_LOW |->
      rsp.payload.year == 14'd1 && rsp.payload.month == 4'd1 && rsp.payload.day == 5'd1)
      else $error("clamped result is not the first day");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.status == STATUS_EXACT || rsp.payload.status == STATUS_LOW
                    || rsp.payload.status == STATUS_HIGH)
      else $error("bad status");
`endif
endmodule

// ----- rtl/core/gda_to_serial.sv -----
// ----------------------------------------------------------------------------
// gda_to_serial
// Two stages: clamp the date fields and split the year, then form the
// serial day number, add the offset and limit it.
// ----------------------------------------------------------------------------
module gda_to_serial #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  gda_pkg::req_type      in_req,
   output logic                  out_valid,
   output logic [gda_pkg::SERIAL_W-2:0] out_serial,
   output logic [gda_pkg::STATUS_W-1:0] out_status
);
   import gda_pkg::*;

   localparam int PM = MAX_YEAR;
   localparam int LAST = PM * 365 + PM / 4 - PM / 100 + PM / 400 - 1;
   localparam logic [SERIAL_W-1:0] LAST_S = SERIAL_W'(LAST);

   // Stage 1: clamped fields, p = year - 1 split by 100.
   logic [YEAR_W+1:0]  p;
   logic [9:0]         cent_in, cent_ff;
   logic [6:0]         rem_in, rem_ff;
   logic [MONTH_W-1:0] m_in, m_ff;
   logic [DAY_W-1:0]   d_in, d_ff;
   logic [OFFSET_W-1:0] off_ff;
   logic [15:0]        y;
   logic [9:0]         yc;
   logic [6:0]         yr;
   logic               lp;
   logic [DAY_W-1:0]   ml;
   logic               v1_ff;

   always_comb begin
      y = {2'b0, in_req.year};
      if (y < 16'd1) y = 16'd1;
      if (y > 16'(MAX_YEAR)) y = 16'(MAX_YEAR);
      p = (YEAR_W+2)'(y - 16'd1);
      // Divide by 100 through a reciprocal, with one correction step.
      cent_in = 10'((64'(p) * 64'd42949673) >> 32);
      rem_in = 7'(p - 16'(cent_in) * 16'd100);
      if (16'(rem_in) >= 16'd100) begin
         cent_in = cent_in + 10'd1;
         rem_in = rem_in - 7'd100;
      end
      yc = 10'((64'(y) * 64'd42949673) >> 32);
      yr = 7'(y - 16'(yc) * 16'd100);
      if (16'(yr) >= 16'd100) begin
         yc = yc + 10'd1;
         yr = yr - 7'd100;
      end
      lp = leap_split(yc, yr);
      m_in = in_req.month;
      if (m_in < 4'd1) m_in = 4'd1;
      if (m_in > 4'd12) m_in = 4'd12;
      ml = month_len(m_in, lp);
      d_in = in_req.day;
      if (d_in < 5'd1) d_in = 5'd1;
      if (d_in > ml) d_in = ml;
   end

   logic lp_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
      if (en) begin
         cent_ff <= cent_in;
         rem_ff  <= rem_in;
         m_ff    <= m_in;
         d_ff    <= d_in;
         off_ff  <= in_req.offset_days;
         lp_ff   <= lp;
      end
   end

   // Stage 2: serial number and limits.
   logic [SERIAL_W-1:0] n;
   logic [SERIAL_W-1:0] pp;
   logic [SERIAL_W-2:0] s_in, s_ff;
   logic [STATUS_W-1:0] st_in, st_ff;
   logic                v2_ff;

   always_comb begin
      pp = SERIAL_W'(cent_ff) * SERIAL_W'(100) + SERIAL_W'(rem_ff);
      n = pp * SERIAL_W'(DAYS_COMMON) + (pp >> 2) - SERIAL_W'(cent_ff)
          + SERIAL_W'(cent_ff >> 2)
          + SERIAL_W'(cum_days(m_ff)) + SERIAL_W'((lp_ff && m_ff > 4'd2) ? 1 : 0)
          + SERIAL_W'(d_ff) - SERIAL_W'(1)
          + {{(SERIAL_W-OFFSET_W){off_ff[OFFSET_W-1]}}, off_ff};
      st_in = STATUS_EXACT;
      s_in = n[SERIAL_W-2:0];
      if (n[SERIAL_W-1]) begin
         s_in = '0;
         st_in = STATUS_LOW;
      end else if (n > LAST_S) begin
         s_in = LAST_S[SERIAL_W-2:0];
         st_in = STATUS_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         s_ff  <= s_in;
         st_ff <= st_in;
      end
   end

   assign out_valid  = v2_ff;
   assign out_serial = s_ff;
   assign out_status = st_ff;
endmodule

// ----- rtl/core/gda_to_date.sv -----
// ----------------------------------------------------------------------------
// gda_to_date
// Three stages turn a serial day number back into year, month and day:
// 400- and 100-year cycles, 4-year and single years, then the month.
// ----------------------------------------------------------------------------
module gda_to_date (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [gda_pkg::SERIAL_W-2:0] in_serial,
   input  logic [gda_pkg::STATUS_W-1:0] in_status,
   output logic                         out_valid,
   output gda_pkg::rsp_type             out_rsp
);
   import gda_pkg::*;

   // Stage A: 400-year cycles by reciprocal, then centuries.
   // The reciprocal rounds down, so the quotient is low by at most one.
   logic [7:0]  q400;
   logic [18:0] r400;
   logic [1:0]  q100_in, q100_ff;
   logic [15:0] r100_in, r100_ff;
   logic [7:0]  q400_ff;
   logic [STATUS_W-1:0] sa_ff, sb_ff;
   logic        va_ff, vb_ff, vc_ff;

   always_comb begin
      q400 = 8'((48'(in_serial) * 48'd1837) >> 28);
      r400 = 19'(32'(in_serial) - 32'(q400) * 32'(DAYS_PER_400Y));
      if (r400 >= 19'(DAYS_PER_400Y)) begin
         q400 = q400 + 8'd1;
         r400 = r400 - 19'(DAYS_PER_400Y);
      end
      if (r400 >= 19'(3 * DAYS_PER_100Y)) begin
         q100_in = 2'd3; r100_in = 16'(r400 - 19'(3 * DAYS_PER_100Y));
      end else if (r400 >= 19'(2 * DAYS_PER_100Y)) begin
         q100_in = 2'd2; r100_in = 16'(r400 - 19'(2 * DAYS_PER_100Y));
      end else if (r400 >= 19'(DAYS_PER_100Y)) begin
         q100_in = 2'd1; r100_in = 16'(r400 - 19'(DAYS_PER_100Y));
      end else begin
         q100_in = 2'd0; r100_in = 16'(r400);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= in_valid;
      if (en) begin
         q400_ff <= q400; q100_ff <= q100_in; r100_ff <= r100_in; sa_ff <= in_status;
      end
   end

   // Stage B: 4-year groups and single years.
   logic [4:0]  q4;
   logic [11:0] r4;
   logic [1:0]  q1;
   logic [8:0]  ry_in, ry_ff;
   logic [15:0] y_in, y_ff;

   always_comb begin
      q4 = 5'((32'(r100_ff) * 32'd2870) >> 22);
      r4 = 12'(r100_ff - 16'(q4) * 16'(DAYS_PER_4Y));
      if (r4 >= 12'(DAYS_PER_4Y)) begin
         q4 = q4 + 5'd1; r4 = r4 - 12'(DAYS_PER_4Y);
      end
      if (r4 >= 12'(3 * DAYS_COMMON)) begin
         q1 = 2'd3; ry_in = 9'(r4 - 12'(3 * DAYS_COMMON));
      end else if (r4 >= 12'(2 * DAYS_COMMON)) begin
         q1 = 2'd2; ry_in = 9'(r4 - 12'(2 * DAYS_COMMON));
      end else if (r4 >= 12'(DAYS_COMMON)) begin
         q1 = 2'd1; ry_in = 9'(r4 - 12'(DAYS_COMMON));
      end else begin
         q1 = 2'd0; ry_in = 9'(r4);
      end
      y_in = 16'(q400_ff) * 16'd400 + 16'(q100_ff) * 16'd100 + 16'(q4) * 16'd4
             + 16'(q1) + 16'd1;
   end

   // The leap test works from the cycle position: q1 of 3 is the fourth year.
   logic lp_in, lp_ff;
   assign lp_in = (q1 == 2'd3) && ((q4 != 5'd24) || (q100_ff == 2'd3));

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (en) vb_ff <= va_ff;
      if (en) begin
         y_ff <= y_in; ry_ff <= ry_in; lp_ff <= lp_in; sb_ff <= sa_ff;
      end
   end

   // Stage C: month and day from the day of year.
   logic [MONTH_W-1:0] m;
   logic [8:0]         base;
   logic [8:0]         start;
   rsp_type            rsp_in, rsp_ff;

   always_comb begin
      m = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         start = cum_days(MONTH_W'(k)) + 9'((lp_ff && k > 2) ? 1 : 0);
         if (ry_ff >= start) m = MONTH_W'(k);
      end
      base = cum_days(m) + 9'((lp_ff && m > 4'd2) ? 1 : 0);
      rsp_in.year   = y_ff[YEAR_W-1:0];
      rsp_in.month  = m;
      rsp_in.day    = DAY_W'(ry_ff - base + 9'd1);
      rsp_in.status = sb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (en) vc_ff <= vb_ff;
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_rsp   = rsp_ff;
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the date add unit against a behavioral calendar predictor, with
// directed edge dates followed by random dates, offsets and handshake gaps.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gda_pkg::*;

   localparam int MAX_YEAR = 9999;
   localparam int N_RANDOM = 1130;

   class date_scoreboard;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      function automatic bit is_leap(int y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      function automatic int month_days(int y, int m);
         int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         if (m == 2 && is_leap(y)) return 29;
         return lens[m-1];
      endfunction

      function automatic longint jan1_serial(int y);
         longint p;
         p = y - 1;
         return p * DAYS_COMMON + p / 4 - p / 100 + p / 400;
      endfunction

      // Computes the shifted date for one accepted item and queues it.
      function void note_date(req_type r);
         int      y, m, d, q400, q100, q4, q1;
         longint  n, last, rem;
         rsp_type e;
         y = r.year;
         m = r.month;
         d = r.day;
         if (y < 1) y = 1;
         if (y > MAX_YEAR) y = MAX_YEAR;
         if (m < 1) m = 1;
         if (m > 12) m = 12;
         if (d < 1) d = 1;
         if (d > month_days(y, m)) d = month_days(y, m);
         n = jan1_serial(y);
         for (int k = 1; k < m; k++) n += month_days(y, k);
         n += d - 1 + longint'($signed(r.offset_days));
         last = jan1_serial(MAX_YEAR + 1) - 1;
         e.status = STATUS_EXACT;
         if (n < 0) begin
            n = 0;
            e.status = STATUS_LOW;
         end else if (n > last) begin
            n = last;
            e.status = STATUS_HIGH;
         end
         rem = n;
         q400 = int'(rem / DAYS_PER_400Y);
         rem = rem % DAYS_PER_400Y;
         q100 = int'(rem / DAYS_PER_100Y);
         if (q100 > 3) q100 = 3;
         rem -= q100 * DAYS_PER_100Y;
         q4 = int'(rem / DAYS_PER_4Y);
         rem = rem % DAYS_PER_4Y;
         q1 = int'(rem / DAYS_COMMON);
         if (q1 > 3) q1 = 3;
         rem -= q1 * DAYS_COMMON;
         y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
         m = 1;
         while (m < 12 && rem >= month_days(y, m)) begin
            rem -= month_days(y, m);
            m++;
         end
         e.year = YEAR_W'(y);
         e.month = MONTH_W'(m);
         e.day = DAY_W'(rem + 1);
         pending.push_back(e);
      endfunction

      function void check_date(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.year !== e.year) begin
            $error("year: expected %0d, got %0d", e.year, a.year);
            errors++;
         end
         if (a.month !== e.month) begin
            $error("month: expected %0d, got %0d", e.month, a.month);
            errors++;
         end
         if (a.day !== e.day) begin
            $error("day: expected %0d, got %0d", e.day, a.day);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   gda_stream_if #(.payload_type(req_type)) req_if();
   gda_stream_if #(.payload_type(rsp_type)) rsp_if();
   date_scoreboard dates = new();
   bit long_hold = 1'b0;

   gregorian_date_add_days_unit #(.MAX_YEAR(MAX_YEAR)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) dates.note_date(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) dates.check_date(rsp_if.payload);
   end

   // Receiver: random stall pattern, with one long hold-off and calm stretches.
   initial begin
      int mode;
      repeat (5) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (60) @(posedge clock);
            long_hold = 1'b0;
         end
         mode = $urandom_range(0, 9);
         if (mode < 3) rsp_if.ready <= 1'b1;
         else if (mode < 8) rsp_if.ready <= $urandom_range(0, 3) != 0;
         else rsp_if.ready <= $urandom_range(0, 3) == 0;
      end
   end

   // Offers one item and holds it until accepted.
   task automatic send_date(int y, int m, int d, int off);
      req_if.valid <= 1'b1;
      req_if.payload <= '{year: YEAR_W'(y), month: MONTH_W'(m), day: DAY_W'(d),
                          offset_days: OFFSET_W'(off)};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic pause_sender();
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic int rand_offset();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 800) - 400;
         1: return $urandom_range(0, 80000) - 40000;
         2: return $urandom_range(0, 7400000) - 3700000;
         default: return int'($signed(24'($urandom())));
      endcase
   endfunction

   initial begin
      int burst, sent, y, m, d;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: field extremes, leap rules, out-of-range fields, both limits.
      send_date(1, 1, 1, 0);
      send_date(1, 1, 1, -1);
      send_date(1, 1, 1, -8388608);
      send_date(9999, 12, 31, 0);
      send_date(9999, 12, 31, 1);
      send_date(1, 1, 1, 8388607);
      send_date(2000, 2, 28, 1);
      send_date(1900, 2, 28, 1);
      send_date(2004, 2, 29, 365);
      send_date(2000, 12, 31, 1);
      send_date(2100, 3, 1, -1);
      send_date(0, 0, 0, 0);
      send_date(16383, 15, 31, 0);
      send_date(1900, 2, 31, 0);
      send_date(2023, 4, 31, 0);
      send_date(1, 1, 1, 3652058);
      send_date(1, 1, 1, 3652059);
      send_date(5000, 6, 15, -1826129);
      send_date(400, 12, 31, 0);
      send_date(8191, 7, 16, -1);
      pause_sender();
      long_hold = 1'b1;
      // Keep offering while the receiver holds so the pipeline backs up.
      for (int i = 0; i < 30; i++)
         send_date($urandom_range(1, MAX_YEAR), $urandom_range(1, 12),
                   $urandom_range(1, 31), rand_offset());
      sent = 0;
      while (sent < N_RANDOM) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst; i++) begin
            y = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 16383)
                                             : $urandom_range(1, MAX_YEAR);
            m = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
            send_date(y, m, d, rand_offset());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender();
      end
      req_if.valid <= 1'b0;
      while (dates.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (dates.errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/core/gda_pkg.sv
rtl/core/gda_stream_if.sv
rtl/core/gda_to_serial.sv
rtl/core/gda_to_date.sv
rtl/core/gregorian_date_add_days_unit.sv
tb/tb.sv
